// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used across the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/dra_pkg.sv =====
// ----------------------------------------------------------------------------
// dra_pkg
// Shared widths, codes and types of the dirty rectangle accumulator.
// ----------------------------------------------------------------------------
package dra_pkg;

   localparam int DRA_RECT_SLOTS = 32;

   localparam int COORD_W = 16;
   localparam int DIM_W   = 15;
   localparam int COUNT_W = 6;
   localparam int SEQ_W   = 32;
   localparam int ROOM_W  = 8;
   localparam int KIND_W  = 2;
   localparam int CSR_IDX_W = 1;

   // request kinds
   localparam logic KIND_ADD   = 1'b0;
   localparam logic KIND_FETCH = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

   typedef enum logic [KIND_W-1:0] {
      ITEM_HEADER = 2'd0,
      ITEM_RECT   = 2'd1,
      ITEM_REJECT = 2'd2
   } item_kind_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CLIP,
      S_COMMIT,
      S_DRAIN
   } state_type;

   typedef struct packed {
      logic [DIM_W-1:0] x;
      logic [DIM_W-1:0] y;
      logic [DIM_W-1:0] w;
      logic [DIM_W-1:0] h;
   } rect_type;

   localparam int RECT_W = $bits(rect_type);

   typedef struct packed {
      logic     valid;
      logic     nonempty;
      rect_type rect;
   } clip_type;

endpackage

// ===== hw/rtl/dra_ram.sv =====
// ----------------------------------------------------------------------------
// dra_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/dra_clip.sv =====
// ----------------------------------------------------------------------------
// dra_clip
// Two-stage rectangle normalizer: order and clamp corners, then size and
// emptiness check.
// ----------------------------------------------------------------------------
module dra_clip import dra_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      launch,
   input  logic signed [COORD_W-1:0] left,
   input  logic signed [COORD_W-1:0] top,
   input  logic signed [COORD_W-1:0] right,
   input  logic signed [COORD_W-1:0] bottom,
   input  logic        [DIM_W-1:0]   screen_w,
   input  logic        [DIM_W-1:0]   screen_h,
   output clip_type                  result
);

   logic signed [COORD_W-1:0] lo_x, hi_x, lo_y, hi_y;
   logic signed [COORD_W-1:0] cl_l, cl_r, cl_t, cl_b;
   logic signed [COORD_W:0]   lim_w, lim_h;

   logic                      a_valid_ff;
   logic signed [COORD_W-1:0] a_l_ff, a_r_ff, a_t_ff, a_b_ff;

   logic signed [COORD_W:0]   dx, dy;
   logic                      b_nonempty;

   clip_type                  b_ff, b_in;

   // stage A: order corners, clamp to the screen
   always_comb begin
      lim_w = $signed({2'b00, screen_w});
      lim_h = $signed({2'b00, screen_h});
      lo_x  = (left > right) ? right : left;
      hi_x  = (left > right) ? left : right;
      lo_y  = (top > bottom) ? bottom : top;
      hi_y  = (top > bottom) ? top : bottom;
      cl_l  = lo_x[COORD_W-1] ? '0 : lo_x;
      cl_t  = lo_y[COORD_W-1] ? '0 : lo_y;
      cl_r  = ($signed({hi_x[COORD_W-1], hi_x}) > lim_w) ? $signed({1'b0, screen_w}) : hi_x;
      cl_b  = ($signed({hi_y[COORD_W-1], hi_y}) > lim_h) ? $signed({1'b0, screen_h}) : hi_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= launch;
      end
      a_l_ff <= cl_l;
      a_r_ff <= cl_r;
      a_t_ff <= cl_t;
      a_b_ff <= cl_b;
   end

   // stage B: size and flag empty or screenless rectangles
   always_comb begin
      dx = $signed({a_r_ff[COORD_W-1], a_r_ff}) - $signed({a_l_ff[COORD_W-1], a_l_ff});
      dy = $signed({a_b_ff[COORD_W-1], a_b_ff}) - $signed({a_t_ff[COORD_W-1], a_t_ff});
      b_nonempty = !dx[COORD_W] && (dx != '0) && !dy[COORD_W] && (dy != '0)
                   && (screen_w != '0) && (screen_h != '0);
      b_in.valid    = a_valid_ff;
      b_in.nonempty = b_nonempty;
      b_in.rect.x   = a_l_ff[DIM_W-1:0];
      b_in.rect.y   = a_t_ff[DIM_W-1:0];
      b_in.rect.w   = dx[DIM_W-1:0];
      b_in.rect.h   = dy[DIM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff.valid <= 1'b0;
      end else begin
         b_ff.valid <= b_in.valid;
      end
      b_ff.nonempty <= b_in.nonempty;
      b_ff.rect     <= b_in.rect;
   end

   assign result = b_ff;

endmodule

// ===== hw/rtl/dirty_rect_accumulator.sv =====
// ----------------------------------------------------------------------------
// dirty_rect_accumulator
// Collects screen update rectangles in a RAM and drains them on request.
// ----------------------------------------------------------------------------
// An add item keeps busy high after start while the rectangle goes through
// the two clip stages and is written to the rectangle RAM. A fetch of n
// stored rectangles gives the header in the cycle after start, then one
// rectangle per cycle as the RAM read port walks the list; busy stays high
// until the last read is issued, so the next item may start in the cycle that
// shows the last rectangle. A rejected fetch or a fetch of an empty list gives
// its single result in the cycle after start and does not raise busy. Results
// appear on rsp_* for one cycle each, marked by rsp_strobe, and must be taken
// as they come.
`include "assert_macros.svh"

module dirty_rect_accumulator import dra_pkg::*; #(
   parameter int RECT_SLOTS = DRA_RECT_SLOTS
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_kind,
   input  logic signed [COORD_W-1:0] req_left,
   input  logic signed [COORD_W-1:0] req_top,
   input  logic signed [COORD_W-1:0] req_right,
   input  logic signed [COORD_W-1:0] req_bottom,
   input  logic signed [ROOM_W-1:0]  req_room,
   // result channel
   output logic                      rsp_strobe,
   output logic [KIND_W-1:0]         rsp_item_kind,
   output logic [SEQ_W-1:0]          rsp_sequence_res,
   output logic [COUNT_W-1:0]        rsp_rect_count,
   output logic [COUNT_W-1:0]        rsp_capacity,
   output logic [DIM_W-1:0]          rsp_pos_x,
   output logic [DIM_W-1:0]          rsp_pos_y,
   output logic [DIM_W-1:0]          rsp_size_w,
   output logic [DIM_W-1:0]          rsp_size_h,
   output logic                      rsp_last,
   // configuration
   input  logic                      csr_we,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [DIM_W-1:0]          csr_wdata
);

   localparam int ADDR_W = (RECT_SLOTS > 1) ? $clog2(RECT_SLOTS) : 1;
   localparam logic [COUNT_W-1:0] SLOTS = COUNT_W'(RECT_SLOTS);

   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 ovf_ff, ovf_in;
   logic [SEQ_W-1:0]     seq_ff, seq_in;
   logic [DIM_W-1:0]     scr_w_ff, scr_w_in;
   logic [DIM_W-1:0]     scr_h_ff, scr_h_in;

   logic [COUNT_W-1:0]   drain_n_ff, drain_n_in;
   logic [COUNT_W-1:0]   drain_idx_ff, drain_idx_in;

   logic                 hdr_valid_ff, hdr_valid_in;
   item_kind_type        hdr_kind_ff, hdr_kind_in;
   logic [SEQ_W-1:0]     hdr_seq_ff, hdr_seq_in;
   logic [COUNT_W-1:0]   hdr_count_ff, hdr_count_in;
   logic [COUNT_W-1:0]   hdr_cap_ff, hdr_cap_in;
   logic                 hdr_last_ff, hdr_last_in;
   logic                 rect_pend_ff, rect_pend_in;
   logic                 rect_last_ff, rect_last_in;

   logic                 accept;
   logic                 reject;
   logic [COUNT_W-1:0]   idx_next;

   clip_type             clip_out;

   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   rect_type             wr_rect;
   logic                 rd_en;
   rect_type             rd_rect;
   logic [RECT_W-1:0]    rd_data;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign reject = req_room[ROOM_W-1] || ({1'b0, req_room[ROOM_W-2:0]} < {1'b0, count_ff});
   assign idx_next = drain_idx_ff + COUNT_W'(1);

   dra_clip u_clip (
      .clock    (clock),
      .reset    (reset),
      .launch   (accept && (req_kind == KIND_ADD)),
      .left     (req_left),
      .top      (req_top),
      .right    (req_right),
      .bottom   (req_bottom),
      .screen_w (scr_w_ff),
      .screen_h (scr_h_ff),
      .result   (clip_out)
   );

   dra_ram #(
      .WIDTH (RECT_W),
      .DEPTH (RECT_SLOTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_rect),
      .rd_en   (rd_en),
      .rd_addr (drain_idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign rd_rect = rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         seq_ff       <= '0;
         scr_w_ff     <= '0;
         scr_h_ff     <= '0;
         hdr_valid_ff <= 1'b0;
         rect_pend_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         seq_ff       <= seq_in;
         scr_w_ff     <= scr_w_in;
         scr_h_ff     <= scr_h_in;
         hdr_valid_ff <= hdr_valid_in;
         rect_pend_ff <= rect_pend_in;
      end
      drain_n_ff   <= drain_n_in;
      drain_idx_ff <= drain_idx_in;
      hdr_kind_ff  <= hdr_kind_in;
      hdr_seq_ff   <= hdr_seq_in;
      hdr_count_ff <= hdr_count_in;
      hdr_cap_ff   <= hdr_cap_in;
      hdr_last_ff  <= hdr_last_in;
      rect_last_ff <= rect_last_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      seq_in       = seq_ff;
      scr_w_in     = scr_w_ff;
      scr_h_in     = scr_h_ff;
      drain_n_in   = drain_n_ff;
      drain_idx_in = drain_idx_ff;
      hdr_valid_in = 1'b0;
      hdr_kind_in  = hdr_kind_ff;
      hdr_seq_in   = hdr_seq_ff;
      hdr_count_in = hdr_count_ff;
      hdr_cap_in   = hdr_cap_ff;
      hdr_last_in  = hdr_last_ff;
      rect_pend_in = 1'b0;
      rect_last_in = rect_last_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[ADDR_W-1:0];
      wr_rect      = clip_out.rect;
      rd_en        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_ADD) begin
                  state_in = S_CLIP;
               end else if (reject) begin
                  hdr_valid_in = 1'b1;
                  hdr_kind_in  = ITEM_REJECT;
                  hdr_seq_in   = '0;
                  hdr_count_in = '0;
                  hdr_cap_in   = '0;
                  hdr_last_in  = 1'b1;
               end else begin
                  hdr_valid_in = 1'b1;
                  hdr_kind_in  = ITEM_HEADER;
                  hdr_seq_in   = seq_ff;
                  hdr_count_in = count_ff;
                  hdr_cap_in   = SLOTS;
                  hdr_last_in  = (count_ff == '0);
                  drain_n_in   = count_ff;
                  drain_idx_in = '0;
                  // the list is handed over; drop it now
                  count_in     = '0;
                  ovf_in       = 1'b0;
                  if (count_ff != '0) begin
                     state_in = S_DRAIN;
                  end
               end
            end
         end
         S_CLIP: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            state_in = S_IDLE;
            if (clip_out.valid && clip_out.nonempty) begin
               seq_in = seq_ff + SEQ_W'(1);
               if (!ovf_ff) begin
                  if (count_ff >= SLOTS) begin
                     // collapse to one full-screen rectangle
                     ovf_in    = 1'b1;
                     count_in  = COUNT_W'(1);
                     wr_en     = 1'b1;
                     wr_addr   = '0;
                     wr_rect.x = '0;
                     wr_rect.y = '0;
                     wr_rect.w = scr_w_ff;
                     wr_rect.h = scr_h_ff;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + COUNT_W'(1);
                  end
               end
            end
         end
         S_DRAIN: begin
            rd_en        = 1'b1;
            rect_pend_in = 1'b1;
            rect_last_in = (idx_next == drain_n_ff);
            drain_idx_in = idx_next;
            if (idx_next == drain_n_ff) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_we) begin
         case (csr_index)
            REG_SCREEN_WIDTH: begin
               scr_w_in = csr_wdata;
               count_in = '0;
               ovf_in   = 1'b0;
            end
            REG_SCREEN_HEIGHT: begin
               scr_h_in = csr_wdata;
               count_in = '0;
               ovf_in   = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // rectangles come straight off the RAM read register
   always_comb begin
      rsp_strobe = hdr_valid_ff || rect_pend_ff;
      if (rect_pend_ff) begin
         rsp_item_kind    = ITEM_RECT;
         rsp_sequence_res = '0;
         rsp_rect_count   = '0;
         rsp_capacity     = '0;
         rsp_pos_x        = rd_rect.x;
         rsp_pos_y        = rd_rect.y;
         rsp_size_w       = rd_rect.w;
         rsp_size_h       = rd_rect.h;
         rsp_last         = rect_last_ff;
      end else begin
         rsp_item_kind    = hdr_kind_ff;
         rsp_sequence_res = hdr_seq_ff;
         rsp_rect_count   = hdr_count_ff;
         rsp_capacity     = hdr_cap_ff;
         rsp_pos_x        = '0;
         rsp_pos_y        = '0;
         rsp_size_w       = '0;
         rsp_size_h       = '0;
         rsp_last         = hdr_last_ff;
      end
   end

   `ASSERT_NEXT(a_add_holds_busy, clock, reset, accept && (req_kind == KIND_ADD), busy, "add item did not hold busy")
   `ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= SLOTS, "stored count exceeds capacity")
   `ASSERT_IMPLIES(a_rect_follows, clock, reset, rect_pend_ff, $past(rsp_strobe), "rectangle without preceding result")
   `ASSERT_IMPLIES(a_clip_in_commit, clock, reset, clip_out.valid, state_ff == S_COMMIT, "clip result outside commit")

endmodule
